### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHECK_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// Payload types and fixed constants of the spot diagram statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sds_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned RMS_W = 25;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned TOTAL_W = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned R2_W = 49;
  localparam int unsigned MEAN_W = 50;
  localparam int unsigned ROOT_W = 25;

  localparam logic [RMS_W-1:0] RMS_MAX = '1;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_WEIGHT = 2'd2;

  localparam logic ADDR_SENSOR_DIAMETER = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [WEIGHT_W-1:0] weight;
    logic has_point;
    logic last;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic [RMS_W-1:0] rms_diameter;
    logic [COORD_W-1:0] x_width;
    logic [COORD_W-1:0] y_width;
    logic [FRAC_W-1:0] encircled_fraction;
    logic [TOTAL_W-1:0] point_total;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

### design/spot_diagram_statistics.sv
// While loading, a point is taken whenever one is offered. After the last request the
// result follows a store read per point, four bit-serial divisions of one quotient
// bit per cycle and a one-bit-per-cycle square root; an empty or weightless set goes
// straight to the output.
// Throughput: a new set is taken once the previous one has moved to the output.
// Reset: synchronous, clears the set, sensor_diameter and the result valid.
// ----------------------------------------------------------------------------
// spot_diagram_statistics
// Weighted centroid, RMS spot diameter, extents and encircled energy of a set
// of weighted points kept in an on-chip point store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spot_diagram_statistics #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  // point channel
  input  wire logic point_valid,
  output logic point_ready,
  input  wire sds_pkg::point_t point,
  // result channel
  output logic result_valid,
  input  wire logic result_ready,
  output sds_pkg::result_t result,
  // register port
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import sds_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned WS_W = WEIGHT_W + CNT_W;
  localparam int unsigned XS_W = COORD_W + WEIGHT_W + CNT_W;
  localparam int unsigned ACC_W = R2_W + WEIGHT_W + CNT_W;
  localparam int unsigned NUM_W = ACC_W;
  localparam int unsigned DC_W = $clog2(NUM_W + 1);
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned SC_W = $clog2(ROOT_W + 1);
  localparam int unsigned ENTRY_W = 2 * COORD_W + WEIGHT_W;
  localparam logic signed [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] NEG_MAX = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [8:0] {
    S_LOAD  = 9'b0_0000_0001,
    S_DIVX  = 9'b0_0000_0010,
    S_DIVY  = 9'b0_0000_0100,
    S_SCAN  = 9'b0_0000_1000,
    S_DIVM  = 9'b0_0001_0000,
    S_SQRT  = 9'b0_0010_0000,
    S_DIVF  = 9'b0_0100_0000,
    S_EMIT  = 9'b0_1000_0000,
    S_START = 9'b1_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic [COORD_W-1:0] sensor_diameter;
  logic [2*COORD_W-1:0] dsq;

  // running set statistics
  logic [CNT_W-1:0] count;
  logic [WS_W-1:0] wsum;
  logic signed [XS_W-1:0] xsum, ysum;
  logic signed [COORD_W-1:0] x_low, x_high, y_low, y_high;

  // point store
  logic [ENTRY_W-1:0] store [MAX_POINTS];
  logic [ENTRY_W-1:0] rd_data;

  // shared divider
  logic [NUM_W-1:0] div_num;
  logic [WS_W:0] div_rem;
  logic [DC_W-1:0] div_cnt;
  logic div_neg;
  logic [WS_W:0] div_sh;
  logic div_ge;

  // scan pipeline
  logic [CNT_W-1:0] issue_cnt;
  logic issuing;
  logic [4:1] pv;
  logic [COORD_W-1:0] ax, ay;
  logic [WEIGHT_W-1:0] w2, w3;
  logic [2*COORD_W-1:0] sqx, sqy;
  logic [WEIGHT_W+ROOT_W-1:0] pp_lo;
  logic [WEIGHT_W+R2_W-ROOT_W-1:0] pp_hi;
  logic [WEIGHT_W-1:0] in_w;
  logic [ACC_W-1:0] acc;
  logic [WS_W-1:0] inside_sum;

  // square root
  logic [MEAN_W-1:0] sq_val;
  logic [REM_W-1:0] sq_rem;
  logic [ROOT_W-1:0] sq_root;
  logic [SC_W-1:0] sq_cnt;
  logic [REM_W-1:0] sq_sh, sq_trial;

  // result fields
  logic signed [COORD_W-1:0] res_cx, res_cy;
  logic [RMS_W-1:0] res_rms;
  logic [FRAC_W-1:0] res_frac;
  logic [STATUS_W-1:0] res_status;

  // accept path
  logic take;
  logic add_pt;
  logic signed [COORD_W+WEIGHT_W:0] prod_x, prod_y;
  logic [CNT_W-1:0] count_next;
  logic [WS_W-1:0] wsum_next;
  logic signed [XS_W-1:0] xsum_next, ysum_next;
  logic [XS_W-1:0] xmag, ymag;

  // stage two and four helpers
  logic signed [COORD_W:0] dx, dy;
  logic [R2_W-1:0] r2;
  logic emit;

  // APB: one register, written on the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_SENSOR_DIAMETER) ? 32'(sensor_diameter) : 32'd0;

  assign point_ready = (state == S_LOAD);
  assign take = point_valid && point_ready;
  assign add_pt = take && point.has_point && (count != CNT_W'(MAX_POINTS));

  assign prod_x = point.pos_x * $signed({1'b0, point.weight});
  assign prod_y = point.pos_y * $signed({1'b0, point.weight});
  assign count_next = add_pt ? count + 1'b1 : count;
  assign wsum_next = add_pt ? wsum + WS_W'(point.weight) : wsum;
  assign xsum_next = add_pt ? xsum + XS_W'(prod_x) : xsum;
  assign ysum_next = add_pt ? ysum + XS_W'(prod_y) : ysum;
  assign xmag = xsum[XS_W-1] ? -xsum : xsum;
  assign ymag = ysum[XS_W-1] ? -ysum : ysum;

  // restoring division step: one quotient bit
  assign div_sh = {div_rem[WS_W-1:0], div_num[NUM_W-1]};
  assign div_ge = div_sh >= {1'b0, wsum};

  // square root step: two radicand bits in, one root bit out
  assign sq_sh = {sq_rem[REM_W-3:0], sq_val[MEAN_W-1 -: 2]};
  assign sq_trial = {sq_root, 2'b01};

  assign issuing = (state == S_SCAN) && (issue_cnt != count);
  assign dx = $signed({rd_data[COORD_W-1], rd_data[COORD_W-1:0]})
              - $signed({res_cx[COORD_W-1], res_cx});
  assign dy = $signed({rd_data[2*COORD_W-1], rd_data[2*COORD_W-1:COORD_W]})
              - $signed({res_cy[COORD_W-1], res_cy});
  assign r2 = R2_W'(sqx) + R2_W'(sqy);

  assign emit = (state == S_EMIT) && (!result_valid || result_ready);

  // point store: write on load, one read per cycle during the scan
  always_ff @(posedge clk) begin
    if (add_pt) begin
      store[count[AW-1:0]] <= {point.weight, point.pos_y, point.pos_x};
    end
    rd_data <= store[issue_cnt[AW-1:0]];
  end

  // scan datapath: difference, square, weight, accumulate
  always_ff @(posedge clk) begin
    ax <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ay <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    w2 <= rd_data[ENTRY_W-1 -: WEIGHT_W];
    sqx <= ax * ax;
    sqy <= ay * ay;
    w3 <= w2;
    pp_lo <= w3 * r2[ROOT_W-1:0];
    pp_hi <= w3 * r2[R2_W-1:ROOT_W];
    // inside the circle when 4 r^2 <= d^2
    in_w <= ({r2, 2'b00} <= (R2_W+2)'(dsq)) ? w3 : '0;
    dsq <= sensor_diameter * sensor_diameter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      sensor_diameter <= '0;
      count <= '0;
      wsum <= '0;
      xsum <= '0;
      ysum <= '0;
      x_low <= POS_MAX;
      y_low <= POS_MAX;
      x_high <= NEG_MAX;
      y_high <= NEG_MAX;
      div_cnt <= '0;
      sq_cnt <= '0;
      pv <= '0;
      issue_cnt <= '0;
      result_valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == ADDR_SENSOR_DIAMETER) begin
        sensor_diameter <= pwdata[COORD_W-1:0];
      end

      // drop the result once taken, unless a new one replaces it
      if (result_valid && result_ready && !emit) begin
        result_valid <= 1'b0;
      end

      // divider runs whenever its counter is armed
      if (div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
        div_rem <= div_ge ? div_sh - {1'b0, wsum} : div_sh;
        div_num <= {div_num[NUM_W-2:0], div_ge};
      end

      if (sq_cnt != '0) begin
        sq_cnt <= sq_cnt - 1'b1;
        sq_val <= {sq_val[MEAN_W-3:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          sq_rem <= sq_sh - sq_trial;
          sq_root <= {sq_root[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem <= sq_sh;
          sq_root <= {sq_root[ROOT_W-2:0], 1'b0};
        end
      end

      pv <= {pv[3:1], issuing};
      if (issuing) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (pv[4]) begin
        acc <= acc + ACC_W'(pp_lo) + (ACC_W'(pp_hi) << ROOT_W);
        inside_sum <= inside_sum + WS_W'(in_w);
      end

      case (state)
        S_LOAD: begin
          if (take) begin
            count <= count_next;
            wsum <= wsum_next;
            xsum <= xsum_next;
            ysum <= ysum_next;
            if (add_pt) begin
              if (point.pos_x < x_low) x_low <= point.pos_x;
              if (point.pos_x > x_high) x_high <= point.pos_x;
              if (point.pos_y < y_low) y_low <= point.pos_y;
              if (point.pos_y > y_high) y_high <= point.pos_y;
            end
            if (point.last) begin
              res_cx <= '0;
              res_cy <= '0;
              res_rms <= '0;
              res_frac <= '0;
              if (count_next == '0) begin
                res_status <= STATUS_EMPTY;
                state <= S_EMIT;
              end else if (wsum_next == '0) begin
                res_status <= STATUS_NO_WEIGHT;
                state <= S_EMIT;
              end else begin
                res_status <= STATUS_OK;
                state <= S_START;
              end
            end
          end
        end
        S_START: begin
          // arm the x centroid division from the registered sum
          div_cnt <= DC_W'(NUM_W);
          div_rem <= '0;
          div_neg <= xsum[XS_W-1];
          div_num <= NUM_W'(xmag);
          state <= S_DIVX;
        end
        S_DIVX: begin
          if (div_cnt == '0) begin
            res_cx <= div_neg ? -div_num[COORD_W-1:0] : div_num[COORD_W-1:0];
            div_cnt <= DC_W'(NUM_W);
            div_rem <= '0;
            div_neg <= ysum[XS_W-1];
            div_num <= NUM_W'(ymag);
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_cnt == '0) begin
            res_cy <= div_neg ? -div_num[COORD_W-1:0] : div_num[COORD_W-1:0];
            issue_cnt <= '0;
            acc <= '0;
            inside_sum <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // all points issued and the pipeline drained
          if (!issuing && pv == '0) begin
            div_cnt <= DC_W'(NUM_W);
            div_rem <= '0;
            div_num <= acc;
            state <= S_DIVM;
          end
        end
        S_DIVM: begin
          if (div_cnt == '0) begin
            sq_val <= div_num[MEAN_W-1:0];
            sq_rem <= '0;
            sq_root <= '0;
            sq_cnt <= SC_W'(ROOT_W);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_cnt == '0) begin
            // saturate twice the root to the field range
            res_rms <= sq_root[ROOT_W-1] ? RMS_MAX : {sq_root[ROOT_W-2:0], 1'b0};
            div_cnt <= DC_W'(NUM_W);
            div_rem <= '0;
            div_num <= NUM_W'({inside_sum, 16'd0});
            state <= S_DIVF;
          end
        end
        S_DIVF: begin
          if (div_cnt == '0) begin
            res_frac <= div_num[FRAC_W-1:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            result_valid <= 1'b1;
            result.centroid_x <= res_cx;
            result.centroid_y <= res_cy;
            result.rms_diameter <= res_rms;
            result.encircled_fraction <= res_frac;
            result.status <= res_status;
            if (res_status == STATUS_EMPTY) begin
              result.x_width <= '0;
              result.y_width <= '0;
              result.point_total <= '0;
            end else begin
              result.x_width <= COORD_W'(x_high - x_low);
              result.y_width <= COORD_W'(y_high - y_low);
              result.point_total <= TOTAL_W'(count);
            end
            // drop the set and start over
            count <= '0;
            wsum <= '0;
            xsum <= '0;
            ysum <= '0;
            x_low <= POS_MAX;
            y_low <= POS_MAX;
            x_high <= NEG_MAX;
            y_high <= NEG_MAX;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `CHECK_PROP(a_count_bound, clk, rst, count <= CNT_W'(MAX_POINTS), "point count over capacity")
  `CHECK_PROP(a_div_idle_load, clk, rst, (state == S_LOAD) |-> (div_cnt == '0), "divider busy in load")
  `CHECK_PROP(a_scan_only, clk, rst, pv[1] |-> (state == S_SCAN), "store read outside scan")
  `CHECK_PROP(a_emit_src, clk, rst, $rose(result_valid) |-> $past(state == S_EMIT), "result without emit")

endmodule

`default_nettype wire

### dv/tb_spot_diagram_statistics.sv
// ----------------------------------------------------------------------------
// tb_spot_diagram_statistics
// Sends point sets through the spot statistics block, predicts each result
// with an in-bench model of the arithmetic, and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_spot_diagram_statistics;
  import sds_pkg::*;

  localparam int unsigned NPTS = 4096;
  localparam longint LIMIT = 3000000;

  logic clk;
  logic rst;
  logic point_valid;
  logic point_ready;
  point_t point;
  logic result_valid;
  logic result_ready;
  result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  spot_diagram_statistics u_dut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_ready(point_ready), .point(point),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: the open set and the sensor register.
  logic signed [23:0] set_x[$];
  logic signed [23:0] set_y[$];
  logic [15:0] set_w[$];
  logic [23:0] diam_q;
  result_t spot_expected[$];
  bit failed;
  bit quiet;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle counter: end the run at a generous limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Close the open set and push its statistics.
  function automatic void close_spot();
    result_t r;
    longint signed sx, sy, xl, xh, yl, yh, cx, cy, dx, dy;
    longint unsigned ws, enclosed, r2, root;
    logic [127:0] acc, dsq;
    r = '0;
    sx = 0; sy = 0; ws = 0; enclosed = 0; acc = 0;
    xl = 8388607; yl = 8388607; xh = -8388608; yh = -8388608;
    if (set_x.size() == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      foreach (set_x[i]) begin
        ws += set_w[i];
        sx += longint'(set_x[i]) * longint'(set_w[i]);
        sy += longint'(set_y[i]) * longint'(set_w[i]);
        if (set_x[i] < xl) xl = set_x[i];
        if (set_x[i] > xh) xh = set_x[i];
        if (set_y[i] < yl) yl = set_y[i];
        if (set_y[i] > yh) yh = set_y[i];
      end
      r.x_width = 24'(xh - xl);
      r.y_width = 24'(yh - yl);
      r.point_total = 13'(set_x.size());
      if (ws == 0) begin
        r.status = STATUS_NO_WEIGHT;
      end else begin
        // SV signed division truncates toward zero, as required.
        cx = sx / longint'(ws);
        cy = sy / longint'(ws);
        dsq = 128'(diam_q) * 128'(diam_q);
        foreach (set_x[i]) begin
          dx = set_x[i] - cx;
          dy = set_y[i] - cy;
          r2 = longint'(dx * dx) + longint'(dy * dy);
          acc += 128'(set_w[i]) * 128'(r2);
          if (128'(r2) * 4 <= dsq) enclosed += set_w[i];
        end
        root = 2 * isqrt(64'(acc / 128'(ws)));
        r.centroid_x = 24'(cx);
        r.centroid_y = 24'(cy);
        r.rms_diameter = (root > 64'(RMS_MAX)) ? RMS_MAX : 25'(root);
        r.encircled_fraction = 17'((enclosed << 16) / ws);
        r.status = STATUS_OK;
      end
    end
    spot_expected.push_back(r);
    set_x.delete(); set_y.delete(); set_w.delete();
  endfunction

  // Send one request and update the predictor when it is taken. Valid stays
  // high into the next request unless an idle burst drops it.
  task automatic send_point(input logic signed [23:0] x, input logic signed [23:0] y,
                            input logic [15:0] w, input bit has, input bit lst);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_valid <= 1'b1;
    point <= '{pos_x: x, pos_y: y, weight: w, has_point: has, last: lst};
    @(posedge clk);
    while (!point_ready) @(posedge clk);
    if (has && set_x.size() < NPTS) begin
      set_x.push_back(x); set_y.push_back(y); set_w.push_back(w);
    end
    if (lst) close_spot();
  endtask

  // Results: compare with the oldest expectation, then, unless quiet, stall in random bursts.
  initial begin
    int stall;
    result_t e;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) begin
        if (spot_expected.size() == 0) begin
          $error("result with nothing expected");
          failed = 1;
        end else begin
          e = spot_expected.pop_front();
          if (result.centroid_x !== e.centroid_x) begin
            $error("centroid_x exp %0d got %0d", e.centroid_x, result.centroid_x); failed = 1;
          end
          if (result.centroid_y !== e.centroid_y) begin
            $error("centroid_y exp %0d got %0d", e.centroid_y, result.centroid_y); failed = 1;
          end
          if (result.rms_diameter !== e.rms_diameter) begin
            $error("rms_diameter exp %0d got %0d", e.rms_diameter, result.rms_diameter);
            failed = 1;
          end
          if (result.x_width !== e.x_width) begin
            $error("x_width exp %0d got %0d", e.x_width, result.x_width); failed = 1;
          end
          if (result.y_width !== e.y_width) begin
            $error("y_width exp %0d got %0d", e.y_width, result.y_width); failed = 1;
          end
          if (result.encircled_fraction !== e.encircled_fraction) begin
            $error("encircled_fraction exp %0d got %0d", e.encircled_fraction,
                   result.encircled_fraction);
            failed = 1;
          end
          if (result.point_total !== e.point_total) begin
            $error("point_total exp %0d got %0d", e.point_total, result.point_total);
            failed = 1;
          end
          if (result.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, result.status); failed = 1;
          end
        end
      end
      if (!quiet && result_ready && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 11);
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
    end
  end

  // Drain, let the block settle, then write the sensor diameter.
  task automatic set_diameter(input logic [23:0] d);
    point_valid <= 1'b0;
    while (spot_expected.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(ADDR_SENSOR_DIAMETER) << 2;
    pwdata <= 32'(d);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    diam_q = d;
  endtask

  task automatic rand_point(input int mode);
    logic signed [23:0] x, y;
    if (mode == 0) begin
      x = 24'($urandom); y = 24'($urandom);
    end else begin
      x = 24'($urandom_range(0, 4000)) - 24'sd2000;
      y = 24'($urandom_range(0, 4000)) - 24'sd2000;
    end
    send_point(x, y, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom), 1'b1, 1'b0);
  endtask

  task automatic test_directed();
    send_point(24'sd0, 24'sd0, 16'd0, 1'b0, 1'b1);              // empty set
    send_point(24'sd5, 24'sd5, 16'd0, 1'b1, 1'b0);              // zero weight
    send_point(-24'sd5, 24'sd9, 16'd0, 1'b1, 1'b1);
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 1'b1, 1'b0); // corners, large spot
    send_point(-24'sh800000, -24'sh800000, 16'hFFFF, 1'b1, 1'b0);
    send_point(24'sd0, 24'sd0, 16'd0, 1'b0, 1'b0);              // ignored item
    send_point(24'sd0, 24'sd0, 16'd0, 1'b0, 1'b1);
    send_point(-24'sd7, 24'sd3, 16'd3, 1'b1, 1'b0);             // negative centroid
    send_point(24'sd2, -24'sd1, 16'd1, 1'b1, 1'b1);
    send_point(24'sd100, 24'sd100, 16'd1, 1'b1, 1'b1);         // one point closes set
  endtask

  task automatic test_random(input int n);
    int k, len, mode;
    k = 0;
    while (k < n) begin
      len = $urandom_range(0, 12);
      mode = $urandom_range(0, 3);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 15) == 0)
          send_point(24'($urandom), 24'($urandom), 16'($urandom), 1'b0, 1'b0);
        rand_point(mode);
      end
      send_point(24'($urandom), 24'($urandom), 16'($urandom),
                 1'($urandom_range(0, 1)), 1'b1);
      k += len + 1;
    end
  endtask

  initial begin
    cycles = 0; failed = 0; quiet = 0; diam_q = '0;
    rst = 1'b1; point_valid = 1'b0; point = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_diameter(24'd3000);
    test_directed();
    test_random(120);
    set_diameter(24'hFFFFFF);
    test_random(80);
    set_diameter(24'd1);
    test_random(100);
    quiet = 1;
    set_diameter(24'd800);
    test_random(100);
    point_valid <= 1'b0;
    while (spot_expected.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
